>>> hw/rtl/base64_stream_encoder_unit_macros.svh
// Assertion helpers shared by the encoder modules.
// Each one expects clk and rst_n in scope.
`ifndef BASE64_STREAM_ENCODER_UNIT_MACROS_SVH
`define BASE64_STREAM_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define B64E_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define B64E_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define B64E_ASSERT_IMPL(label, ante, cons)
`define B64E_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/b64e_pkg.sv
package b64e_pkg;

  localparam int CHAR_W        = 7;
  localparam int QDEPTH_DEF    = 2;
  localparam int SLOTS         = 4;

  localparam logic [CHAR_W-1:0] PAD_CHAR   = 7'd61;  // '='
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 7'd43;  // '+'
  localparam logic [CHAR_W-1:0] SLASH_CHAR = 7'd47;  // '/'

  // One byte's worth of output characters, as built by the front end
  typedef struct packed {
    logic [SLOTS-1:0][5:0] sext;      // sextet per character slot
    logic [SLOTS-1:0]      pad;       // slot is '=' padding
    logic [1:0]            last_idx;  // index of the final slot in use
    logic                  last;      // job closes the message
  } job_t;

  // Map a sextet onto the standard alphabet
  function automatic logic [CHAR_W-1:0] sextet_to_ascii(input logic [5:0] v);
    logic [CHAR_W-1:0] w;
    w = {1'b0, v};
    if (v < 6'd26)      return w + 7'd65;
    else if (v < 6'd52) return w + 7'd71;
    else if (v < 6'd62) return w - 7'd4;
    else if (v == 6'd62) return PLUS_CHAR;
    else                return SLASH_CHAR;
  endfunction

endpackage

>>> hw/rtl/base64_stream_encoder_unit.sv
// Channel   Handshake          Payload
// input     push / full        in_data_byte[7:0], in_last_byte
// result    empty / pop        out_char[6:0], out_last_char
//
// A byte is taken in any cycle the job queue has room; each byte becomes a job
// of one to four characters. The character emitter puts out one character per
// cycle while it holds a job and the result does not stall, so three bytes
// yield four characters. Reset (rst_n low, synchronous) clears group position,
// queue and output. A stalled result (pop low) holds the output; the queue
// keeps taking bytes until it fills.
module base64_stream_encoder_unit #(
  parameter int QDEPTH = b64e_pkg::QDEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_byte,
  input  logic                        push,
  output logic                        full,
  output logic [b64e_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last_char,
  output logic                        empty,
  input  logic                        pop
);
  import b64e_pkg::*;

  job_t wr_job, rd_job;
  logic q_push, q_pop, q_full, q_empty;

  assign full = q_full;

  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .push         (push),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (wr_job)
  );

  b64e_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (wr_job),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (rd_job),
    .empty   (q_empty)
  );

  b64e_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (rd_job),
    .q_pop         (q_pop),
    .out_char      (out_char),
    .out_last_char (out_last_char),
    .empty         (empty),
    .pop           (pop)
  );

endmodule

>>> hw/rtl/b64e_front.sv
module b64e_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  input  logic          push,
  input  logic          q_full,
  output logic          q_push,
  output b64e_pkg::job_t q_data
);
  import b64e_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;
  job_t       job;

  // Accept a byte whenever the job queue has room
  assign q_push = push && !q_full;
  assign q_data = job;

  // Split the byte into sextets according to the group position
  always_comb begin
    job       = '0;
    phase_nxt = 2'd0;
    left_nxt  = 4'd0;
    case (phase_r)
      2'd1: begin
        job.sext[0] = {left_r[1:0], in_data_byte[7:4]};
        if (in_last_byte) begin
          job.sext[1]  = {in_data_byte[3:0], 2'b00};
          job.pad[2]   = 1'b1;
          job.last_idx = 2'd2;
          job.last     = 1'b1;
        end else begin
          job.last_idx = 2'd0;
          left_nxt     = in_data_byte[3:0];
          phase_nxt    = 2'd2;
        end
      end
      2'd2: begin
        job.sext[0]  = {left_r, in_data_byte[7:6]};
        job.sext[1]  = in_data_byte[5:0];
        job.last_idx = 2'd1;
        job.last     = in_last_byte;
      end
      default: begin
        job.sext[0] = in_data_byte[7:2];
        if (in_last_byte) begin
          job.sext[1]  = {in_data_byte[1:0], 4'b0000};
          job.pad[2]   = 1'b1;
          job.pad[3]   = 1'b1;
          job.last_idx = 2'd3;
          job.last     = 1'b1;
        end else begin
          job.last_idx = 2'd0;
          left_nxt     = {2'b00, in_data_byte[1:0]};
          phase_nxt    = 2'd1;
        end
      end
    endcase
  end

  // Advance group state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      left_r  <= 4'd0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

>>> hw/rtl/b64e_queue.sv
`include "base64_stream_encoder_unit_macros.svh"

module b64e_queue #(
  parameter int DEPTH = b64e_pkg::QDEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  b64e_pkg::job_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output b64e_pkg::job_t rd_data,
  output logic           empty
);
  import b64e_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = slot_r[rd_ptr_r];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  `B64E_ASSERT_IMPL(a_no_overflow, wr_en, !full)
  `B64E_ASSERT_IMPL(a_no_underflow, rd_en, !empty)

endmodule

>>> hw/rtl/b64e_back.sv
`include "base64_stream_encoder_unit_macros.svh"

module b64e_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  b64e_pkg::job_t                q_data,
  output logic                          q_pop,
  output logic [b64e_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last_char,
  output logic                          empty,
  input  logic                          pop
);
  import b64e_pkg::*;

  job_t              cur_job_r;
  logic              cur_valid_r;
  logic [1:0]        cur_idx_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r, char_nxt;
  logic              out_last_r, last_nxt;
  logic              out_free, emit, cur_done;

  // Hand the next character to the output register when it frees up
  assign out_free = !out_valid_r || pop;
  assign emit     = cur_valid_r && out_free;
  assign cur_done = emit && (cur_idx_r == cur_job_r.last_idx);
  assign q_pop    = !q_empty && (!cur_valid_r || cur_done);

  assign char_nxt = cur_job_r.pad[cur_idx_r] ? PAD_CHAR
                                             : sextet_to_ascii(cur_job_r.sext[cur_idx_r]);
  assign last_nxt = cur_job_r.last && (cur_idx_r == cur_job_r.last_idx);

  // Step through the slots of the current job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_idx_r   <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        cur_idx_r   <= 2'd0;
      end else if (cur_done) begin
        cur_valid_r <= 1'b0;
      end else if (emit) begin
        cur_idx_r <= cur_idx_r + 2'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold job and character payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_job_r <= q_data;
    end
    if (emit) begin
      out_char_r <= char_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;
  assign empty         = !out_valid_r;

  `B64E_ASSERT_IMPL(a_idx_in_job, cur_valid_r, cur_idx_r <= cur_job_r.last_idx)
  `B64E_ASSERT_IMPL(a_pad_only_at_end, emit && cur_job_r.pad[cur_idx_r], cur_job_r.last)

endmodule
